// File: src/qce_pkg.sv
package qce_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_FLOW = 2'd0;
    localparam logic [1:0] OP_DIST = 2'd1;
    localparam logic [1:0] OP_PERM = 2'd2;
    localparam logic [1:0] OP_EVAL = 2'd3;

    localparam int COST_W = 48;
    localparam logic [COST_W-1:0] COST_CAP = {COST_W{1'b1}};

    localparam int SIZE_W = 6;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic issue;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_term;
        logic pipe_busy;
        logic size_zero;
    } t_dp_status;

endpackage

// File: src/qce_ram.sv
module qce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/qce_ctrl.sv
module qce_ctrl import qce_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_operation,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_operation == OP_EVAL) begin
                        o_cmd.clear = 1'b1;
                        n_state = i_status.size_zero ? ST_DONE : ST_RUN;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_status.last_term) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/qce_datapath.sv
module qce_datapath import qce_pkg::*; #(
    parameter int MAX_SIZE   = 32,
    parameter int ENTRY_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [1:0]        i_operation,
    input  logic [4:0]        i_row,
    input  logic [4:0]        i_col,
    input  logic [15:0]       i_entry_value,
    input  logic              i_cfg_wr_en,
    input  logic [SIZE_W-1:0] i_cfg_wr_data,
    output t_dp_status        o_status,
    output logic [COST_W-1:0] o_total_cost,
    output logic              o_index_error
);

    localparam int IDX_W     = $clog2(MAX_SIZE);
    localparam int N_W       = IDX_W + 1;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MAT_DEPTH = 1 << ADDR_W;
    localparam int PERM_W    = IDX_W + 1;
    localparam int PROD_W    = 2 * ENTRY_BITS;
    localparam int SUM_W     = ((PROD_W > COST_W) ? PROD_W : COST_W) + 1;

    logic [SIZE_W-1:0]     r_size;
    logic [N_W-1:0]        n_active;
    logic [IDX_W-1:0]      last_idx;

    logic [IDX_W-1:0]      r_i;
    logic [IDX_W-1:0]      r_j;

    logic                  row_ok;
    logic                  col_ok;
    logic [IDX_W-1:0]      row_idx;
    logic [IDX_W-1:0]      col_idx;
    logic [ENTRY_BITS-1:0] entry_w;
    logic [PERM_W-1:0]     perm_wdata;
    logic                  flow_we;
    logic                  dist_we;
    logic                  perm_we;

    logic [ENTRY_BITS-1:0] flow_rd;
    logic [ENTRY_BITS-1:0] dist_rd;
    logic [PERM_W-1:0]     pa_rd;
    logic [PERM_W-1:0]     pb_rd;

    logic                  r_v1;
    logic                  r_v2;
    logic                  r_v3;
    logic [ENTRY_BITS-1:0] r_flow2;
    logic [PROD_W-1:0]     r_prod;
    logic [COST_W-1:0]     r_acc;
    logic                  r_err;
    logic [SUM_W-1:0]      acc_sum;
    logic                  term_bad;

    // active size, clamped to the array size
    assign n_active = (32'(r_size) > MAX_SIZE) ? N_W'(MAX_SIZE) : N_W'(r_size);
    assign last_idx = IDX_W'(n_active - 1'b1);

    // load decode
    assign row_ok     = 32'(i_row) < MAX_SIZE;
    assign col_ok     = 32'(i_col) < MAX_SIZE;
    assign row_idx    = IDX_W'(i_row);
    assign col_idx    = IDX_W'(i_col);
    assign entry_w    = ENTRY_BITS'(i_entry_value);
    assign perm_wdata = {32'(i_entry_value) >= MAX_SIZE, IDX_W'(i_entry_value)};
    assign flow_we    = i_cmd.load && (i_operation == OP_FLOW) && row_ok && col_ok;
    assign dist_we    = i_cmd.load && (i_operation == OP_DIST) && row_ok && col_ok;
    assign perm_we    = i_cmd.load && (i_operation == OP_PERM) && row_ok;

    qce_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAT_DEPTH)) u_flow_ram (
        .i_clk   (i_clk),
        .i_we    (flow_we),
        .i_waddr ({row_idx, col_idx}),
        .i_wdata (entry_w),
        .i_raddr ({r_i, r_j}),
        .o_rdata (flow_rd)
    );

    qce_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAT_DEPTH)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr ({row_idx, col_idx}),
        .i_wdata (entry_w),
        .i_raddr ({pa_rd[IDX_W-1:0], pb_rd[IDX_W-1:0]}),
        .o_rdata (dist_rd)
    );

    // two copies of the permutation, one read by row and one by column
    qce_ram #(.WIDTH(PERM_W), .DEPTH(MAX_SIZE)) u_perm_row_ram (
        .i_clk   (i_clk),
        .i_we    (perm_we),
        .i_waddr (row_idx),
        .i_wdata (perm_wdata),
        .i_raddr (r_i),
        .o_rdata (pa_rd)
    );

    qce_ram #(.WIDTH(PERM_W), .DEPTH(MAX_SIZE)) u_perm_col_ram (
        .i_clk   (i_clk),
        .i_we    (perm_we),
        .i_waddr (row_idx),
        .i_wdata (perm_wdata),
        .i_raddr (r_j),
        .o_rdata (pb_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_size <= i_cfg_wr_data;
        end
    end

    // term counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
        end else if (i_cmd.clear) begin
            r_i <= '0;
            r_j <= '0;
        end else if (i_cmd.issue) begin
            if (r_j == last_idx) begin
                r_j <= '0;
                r_i <= r_i + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flow2 <= flow_rd;
        r_prod  <= PROD_W'(r_flow2) * PROD_W'(dist_rd);
    end

    assign term_bad = pa_rd[IDX_W] || pb_rd[IDX_W]
                   || ({1'b0, pa_rd[IDX_W-1:0]} >= n_active)
                   || ({1'b0, pb_rd[IDX_W-1:0]} >= n_active);

    assign acc_sum = SUM_W'(r_acc) + SUM_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_err <= 1'b0;
        end else if (i_cmd.clear) begin
            r_acc <= '0;
            r_err <= 1'b0;
        end else begin
            if (r_v1 && term_bad) begin
                r_err <= 1'b1;
            end
            if (r_v3) begin
                r_acc <= (acc_sum > SUM_W'(COST_CAP)) ? COST_CAP : COST_W'(acc_sum);
            end
        end
    end

    assign o_status.last_term = (r_i == last_idx) && (r_j == last_idx);
    assign o_status.pipe_busy = r_v1 || r_v2 || r_v3;
    assign o_status.size_zero = (n_active == '0);

    assign o_total_cost  = r_err ? '0 : r_acc;
    assign o_index_error = r_err;

endmodule

// File: src/qap_cost_evaluator_unit.sv
// channel   | handshake             | payload
// ----------+-----------------------+-----------------------------------------------
// command   | i_start / o_busy      | i_operation, i_row, i_col, i_entry_value
// config    | i_cfg_wr_en           | i_cfg_wr_data (size_in_use)
// result    | o_done (1-cycle)      | o_total_cost, o_index_error
//
// a load word (flow, distance or permutation entry) is taken while busy stays low
// an evaluate word holds busy at active size n through the walk of n*n terms and the pipeline
// drain, with the result strobe at the end: one multiply-accumulate per cycle, set by the single
// read port of the distance ram; at size zero busy and the strobe last one cycle
// the result strobe is high for one cycle and the receiver cannot stall it
// synchronous active-low reset returns the controller to idle and size_in_use to 32;
// matrix and permutation rams are not cleared
module qap_cost_evaluator_unit import qce_pkg::*; #(
    parameter int MAX_SIZE   = 32,
    parameter int ENTRY_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command word
    input  logic              i_start,
    output logic              o_busy,
    input  logic [1:0]        i_operation,
    input  logic [4:0]        i_row,
    input  logic [4:0]        i_col,
    input  logic [15:0]       i_entry_value,
    // size register
    input  logic              i_cfg_wr_en,
    input  logic [SIZE_W-1:0] i_cfg_wr_data,
    // result word
    output logic              o_done,
    output logic [COST_W-1:0] o_total_cost,
    output logic              o_index_error
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // controller sequences load, term walk, pipeline drain and result strobe
    qce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operation (i_operation),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd),
        .o_busy      (o_busy),
        .o_done      (o_done)
    );

    // datapath: rams, term counters, 4-stage read/multiply/accumulate pipe
    // index error is gathered from every permutation entry seen during the walk
    qce_datapath #(
        .MAX_SIZE   (MAX_SIZE),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_operation   (i_operation),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_entry_value (i_entry_value),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_status      (dp_status),
        .o_total_cost  (o_total_cost),
        .o_index_error (o_index_error)
    );

endmodule

// File: src/qce_checker.sv
module qce_checker import qce_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic [1:0]        i_operation,
    input logic              o_done,
    input logic [COST_W-1:0] o_total_cost,
    input logic              o_index_error
);

    // an evaluate word makes the block busy
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_operation == OP_EVAL) |=> o_busy)
        else $error("evaluate accepted but block not busy");

    // a load word gives no result and leaves the block idle
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_operation != OP_EVAL) |=> (!o_busy && !o_done))
        else $error("load word caused busy or result");

    // a result is strobed only while the block is busy
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy)
        else $error("result strobe outside a busy period");

    // after a result the block is idle again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy)
        else $error("block still busy after result");

    // an index error carries zero cost
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_index_error) |-> (o_total_cost == '0))
        else $error("index error with nonzero cost");

endmodule

bind qap_cost_evaluator_unit qce_checker u_qce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .i_operation   (i_operation),
    .o_done        (o_done),
    .o_total_cost  (o_total_cost),
    .o_index_error (o_index_error)
);
